[design/cpwf_pkg.sv]
// types, codes and the crc-8 step shared by the framer modules
package cpwf_pkg;

   localparam logic [1:0] OP_CMD = 2'd0;
   localparam logic [1:0] OP_ARG = 2'd1;
   localparam logic [1:0] OP_RX  = 2'd2;

   localparam logic CSR_POLY = 1'b0;
   localparam logic CSR_INIT = 1'b1;

   localparam logic [7:0] POLY_RESET = 8'h31;
   localparam logic [7:0] INIT_RESET = 8'hFF;

   localparam logic KIND_TX = 1'b0;
   localparam logic KIND_RX = 1'b1;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] word_in;
      logic [7:0]  byte_in;
      logic        item_last;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  byte_out;
      logic [15:0] word_out;
      logic        crc_ok;
      logic        frame_error;
      logic        run_last;
   } rsp_type;

   typedef enum logic [1:0] {
      ENTRY_CMD,
      ENTRY_ARG,
      ENTRY_RX
   } entry_kind_type;

   typedef struct packed {
      entry_kind_type kind;
      logic [15:0]    word;
      logic [7:0]     crc;
      logic           ok;
      logic           fe;
      logic           last;
   } entry_type;

   function automatic logic [7:0] crc_feed(input logic [7:0] poly,
                                           input logic [7:0] crc,
                                           input logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ poly;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

[design/cpwf_queue.sv]
// short register queue between front and back
module cpwf_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cpwf_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output cpwf_pkg::entry_type head,
   output logic                empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cpwf_pkg::entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slots_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         slots_ff[wr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

endmodule

[design/cpwf_front.sv]
// request intake: decode, receive triple tracking, receive crc and first argument crc step
module cpwf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  cpwf_pkg::req_type   req_data,
   input  logic [7:0]          crc_polynomial,
   input  logic [7:0]          crc_initial,
   input  logic                queue_full,
   output logic                push,
   output cpwf_pkg::entry_type push_entry
);

   logic [1:0] pos_ff, pos_in;
   logic [7:0] high_ff, high_in;
   logic [7:0] low_ff, low_in;
   logic [7:0] crc_ff, crc_in;
   logic       err_ff, err_in;
   logic       take;
   logic       err_next;

   assign req_ready = !queue_full;
   assign take      = req_valid && req_ready;

   always_comb begin
      pos_in     = pos_ff;
      high_in    = high_ff;
      low_in     = low_ff;
      crc_in     = crc_ff;
      err_in     = err_ff;
      push       = 1'b0;
      err_next   = err_ff;
      push_entry = '{kind: cpwf_pkg::ENTRY_CMD, word: req_data.word_in, crc: 8'h00,
                     ok: 1'b0, fe: 1'b0, last: req_data.item_last};
      if (take) begin
         unique case (req_data.opcode)
            cpwf_pkg::OP_CMD: begin
               push = 1'b1;
            end
            cpwf_pkg::OP_ARG: begin
               push            = 1'b1;
               push_entry.kind = cpwf_pkg::ENTRY_ARG;
               push_entry.crc  = cpwf_pkg::crc_feed(crc_polynomial, crc_initial,
                                                    req_data.word_in[15:8]);
            end
            cpwf_pkg::OP_RX: begin
               push_entry.kind = cpwf_pkg::ENTRY_RX;
               if (pos_ff == 2'd2) begin
                  err_next        = err_ff || (crc_ff != req_data.byte_in);
                  push            = 1'b1;
                  push_entry.word = {high_ff, low_ff};
                  push_entry.ok   = (crc_ff == req_data.byte_in);
                  push_entry.fe   = err_next;
                  pos_in          = 2'd0;
                  err_in          = req_data.item_last ? 1'b0 : err_next;
               end else if (pos_ff == 2'd1) begin
                  low_in          = req_data.byte_in;
                  crc_in          = cpwf_pkg::crc_feed(crc_polynomial, crc_ff,
                                                       req_data.byte_in);
                  pos_in          = 2'd2;
                  push_entry.word = {high_ff, req_data.byte_in};
                  push_entry.fe   = 1'b1;
                  if (req_data.item_last) begin
                     push   = 1'b1;
                     pos_in = 2'd0;
                     err_in = 1'b0;
                  end
               end else begin
                  high_in         = req_data.byte_in;
                  crc_in          = cpwf_pkg::crc_feed(crc_polynomial, crc_initial,
                                                       req_data.byte_in);
                  pos_in          = 2'd1;
                  push_entry.word = {req_data.byte_in, 8'h00};
                  push_entry.fe   = 1'b1;
                  if (req_data.item_last) begin
                     push   = 1'b1;
                     pos_in = 2'd0;
                     err_in = 1'b0;
                  end
               end
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 2'd0;
         high_ff <= 8'h00;
         low_ff  <= 8'h00;
         crc_ff  <= cpwf_pkg::INIT_RESET;
         err_ff  <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         high_ff <= high_in;
         low_ff  <= low_in;
         crc_ff  <= crc_in;
         err_ff  <= err_in;
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff != 2'd3)
      else $error("triple position out of range");

endmodule

[design/cpwf_back.sv]
// result sequencer: expands queue entries into bus bytes and word results
module cpwf_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          crc_polynomial,
   input  cpwf_pkg::entry_type head,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cpwf_pkg::rsp_type   rsp_data
);

   logic [1:0]        idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   cpwf_pkg::rsp_type rsp_ff, rsp_in;
   logic              out_free;
   logic              emit;
   logic              final_res;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = !empty && out_free;
   assign final_res = (head.kind == cpwf_pkg::ENTRY_RX)
                   || ((head.kind == cpwf_pkg::ENTRY_CMD) && (idx_ff == 2'd1))
                   || ((head.kind == cpwf_pkg::ENTRY_ARG) && (idx_ff == 2'd2));
   assign pop       = emit && final_res;

   always_comb begin
      rsp_in          = '0;
      rsp_in.run_last = final_res && head.last;
      if (head.kind == cpwf_pkg::ENTRY_RX) begin
         rsp_in.kind        = cpwf_pkg::KIND_RX;
         rsp_in.word_out    = head.word;
         rsp_in.crc_ok      = head.ok;
         rsp_in.frame_error = head.fe;
      end else begin
         rsp_in.kind = cpwf_pkg::KIND_TX;
         case (idx_ff)
            2'd0:    rsp_in.byte_out = head.word[15:8];
            2'd1:    rsp_in.byte_out = head.word[7:0];
            default: rsp_in.byte_out = cpwf_pkg::crc_feed(crc_polynomial, head.crc,
                                                         head.word[7:0]);
         endcase
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (emit) begin
         idx_in = final_res ? 2'd0 : idx_ff + 2'd1;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_idx_has_head: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 2'd0) |-> !empty)
      else $error("byte index running without a queued entry");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 2'd3) && !((head.kind == cpwf_pkg::ENTRY_RX) && (idx_ff != 2'd0)))
      else $error("byte index out of range for entry");

endmodule

[design/crc_protected_word_framer.sv]
// top level of the crc-8 protected 16-bit word framer and deframer
//
//   port group  | dir | handshake             | payload
//   req_*       | in  | req_valid/req_ready   | req_data  (opcode, word_in, byte_in, item_last)
//   rsp_*       | out | rsp_valid/rsp_ready   | rsp_data  (kind, byte_out, word_out, ...)
//   csr_*       | in  | csr_valid/csr_ready   | csr_index, csr_data
//
// a request is taken while the queue has room; the back end
// sends one result a cycle unless rsp_ready holds it off: 2 for a command word,
// 3 for an argument word, 0 or 1 for a received byte
// a pushed entry goes through a queue slot and the result register before it shows on rsp_valid
// synchronous reset clears queue, receive state and the result valid flag;
// csr registers return to polynomial 0x31 and initial value 0xFF
// a stalled rsp_ready fills the queue, then req_ready drops
module crc_protected_word_framer #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cpwf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cpwf_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [7:0]        csr_data
);

   logic [7:0]          poly_ff;
   logic [7:0]          init_ff;
   logic                queue_full;
   logic                queue_empty;
   logic                push;
   logic                pop;
   cpwf_pkg::entry_type push_entry;
   cpwf_pkg::entry_type head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= cpwf_pkg::POLY_RESET;
         init_ff <= cpwf_pkg::INIT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            cpwf_pkg::CSR_POLY: poly_ff <= csr_data;
            default:            init_ff <= csr_data;
         endcase
      end
   end

   cpwf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .crc_polynomial (poly_ff),
      .crc_initial    (init_ff),
      .queue_full     (queue_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   cpwf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head       (head),
      .empty      (queue_empty)
   );

   cpwf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .crc_polynomial (poly_ff),
      .head           (head),
      .empty          (queue_empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data)
   );

endmodule
